@@ src/lcse_pkg.sv @@
// ----------------------------------------------------------------------------
// lcse_pkg
// Shared types and constants of the line centroid steering error block.
// ----------------------------------------------------------------------------
package lcse_pkg;

  // limits on counted rows and columns
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  // field widths
  localparam int PIXEL_W  = 8;
  localparam int COORD_W  = 10;
  localparam int RSUM_W   = 20;
  localparam int RCNT_W   = 11;
  localparam int CSUM_W   = 24;
  localparam int ERR_W    = 16;
  localparam int DRV_W    = 17;

  // serial divider
  localparam int DIV_NUM_W = 26;
  localparam int DIV_DEN_W = 12;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // row record queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_BAND_TOP      = 3'd0;
  localparam logic [2:0] REG_BAND_ROWS     = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [2:0] REG_CENTER_OFFSET = 3'd3;
  localparam logic [2:0] REG_STEER_GAIN    = 3'd4;

  localparam logic [9:0]  RST_BAND_TOP      = 10'd320;
  localparam logic [10:0] RST_BAND_ROWS     = 11'd24;
  localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [9:0]  RST_CENTER_OFFSET = 10'd30;
  localparam logic [15:0] RST_STEER_GAIN    = 16'hFF0A;

  typedef struct packed {
    logic [9:0]         band_top;
    logic [10:0]        band_rows;
    logic [10:0]        image_width;
    logic [9:0]         center_offset;
    logic signed [15:0] steer_gain;
  } cfg_t;

  // one closed row handed from front to back
  typedef struct packed {
    logic              frame_end;
    logic [RCNT_W-1:0] cnt;
    logic [RSUM_W-1:0] sum;
  } row_rec_t;

endpackage

@@ src/line_centroid_steering_error.sv @@
// ----------------------------------------------------------------------------
// line_centroid_steering_error
// Steering error and drive from the line centroid of a band of mask rows.
//
//   port group  role    transaction
//   in_*        slave   one mask pixel, tlast = frame end, tuser = row end
//   out_*       master  one result per frame: error, drive, line found
//   cfg_*       apb     register writes and reads, pready always high
//
// pixels are taken one per cycle while the row record queue has room
// each row end with line pixels costs the back part a serial 26-bit divide,
// an empty row only the record check; four queued rows absorb short bursts,
// and rows closing faster than the back part handles them stall in_tready
// a frame end with line rows adds a second divide, the error and drive math
// in S_ERR, S_MUL and S_DRV, and the load of the result register in S_OUT
// the result waits in an output register; the back part stalls on it only
// when the next frame end arrives before it is taken
// reset (synchronous, rst_n low) clears counters, queue and result valid
// ----------------------------------------------------------------------------
module line_centroid_steering_error (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel[7:0], column[17:8], row[27:18], zero pad
  input  logic        in_tlast,   // frame_end
  input  logic        in_tuser,   // row_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // steer_error[15:0], drive[32:16], zero pad
  output logic        out_tuser,  // line_found
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  lcse_pkg::cfg_t      cfg_r, cfg_nxt;
  lcse_pkg::row_rec_t  push_rec, head_rec;
  logic                push, pop, q_full, q_empty, wr_en;
  logic [2:0]          reg_idx;
  logic [15:0]         res_err;
  logic [16:0]         res_drv;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        lcse_pkg::REG_BAND_TOP:      cfg_nxt.band_top      = cfg_pwdata[9:0];
        lcse_pkg::REG_BAND_ROWS:     cfg_nxt.band_rows     = cfg_pwdata[10:0];
        lcse_pkg::REG_IMAGE_WIDTH:   cfg_nxt.image_width   = cfg_pwdata[10:0];
        lcse_pkg::REG_CENTER_OFFSET: cfg_nxt.center_offset = cfg_pwdata[9:0];
        lcse_pkg::REG_STEER_GAIN:    cfg_nxt.steer_gain    = cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lcse_pkg::REG_BAND_TOP:      cfg_prdata = 32'(cfg_r.band_top);
      lcse_pkg::REG_BAND_ROWS:     cfg_prdata = 32'(cfg_r.band_rows);
      lcse_pkg::REG_IMAGE_WIDTH:   cfg_prdata = 32'(cfg_r.image_width);
      lcse_pkg::REG_CENTER_OFFSET: cfg_prdata = 32'(cfg_r.center_offset);
      lcse_pkg::REG_STEER_GAIN:    cfg_prdata = {16'h0000, cfg_r.steer_gain};
      default:                     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_top      <= lcse_pkg::RST_BAND_TOP;
      cfg_r.band_rows     <= lcse_pkg::RST_BAND_ROWS;
      cfg_r.image_width   <= lcse_pkg::RST_IMAGE_WIDTH;
      cfg_r.center_offset <= lcse_pkg::RST_CENTER_OFFSET;
      cfg_r.steer_gain    <= lcse_pkg::RST_STEER_GAIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .pixel     (in_tdata[7:0]),
    .column    (in_tdata[17:8]),
    .row       (in_tdata[27:18]),
    .row_end   (in_tuser),
    .frame_end (in_tlast),
    .push      (push),
    .push_rec  (push_rec),
    .q_full    (q_full)
  );

  lcse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (q_empty)
  );

  lcse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_rec  (head_rec),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_err   (res_err),
    .out_drv   (res_drv),
    .out_found (out_tuser)
  );

  assign out_tdata = {7'b0000000, res_drv, res_err};

endmodule

@@ src/lcse_queue.sv @@
// ----------------------------------------------------------------------------
// lcse_queue
// Small first-in first-out queue of closed row records.
// ----------------------------------------------------------------------------
module lcse_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcse_pkg::row_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output lcse_pkg::row_rec_t head_rec,
  output logic              empty
);

  lcse_pkg::row_rec_t                 mem_r [lcse_pkg::QDEPTH];
  logic [lcse_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [lcse_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [lcse_pkg::QPTR_W:0]          count_r, count_nxt;
  logic                               do_push, do_pop;

  assign full     = (count_r == (lcse_pkg::QPTR_W+1)'(lcse_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign head_rec = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

@@ src/lcse_front.sv @@
// ----------------------------------------------------------------------------
// lcse_front
// Takes pixels, keeps the running column sum and count of the current row
// and hands a record to the queue at each row or frame end.
// ----------------------------------------------------------------------------
module lcse_front (
  input  logic                clk,
  input  logic                rst_n,
  input  lcse_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          pixel,
  input  logic [9:0]          column,
  input  logic [9:0]          row,
  input  logic                row_end,
  input  logic                frame_end,
  output logic                push,
  output lcse_pkg::row_rec_t  push_rec,
  input  logic                q_full
);

  logic [lcse_pkg::RSUM_W-1:0] sum_r, sum_nxt, sum_upd;
  logic [lcse_pkg::RCNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic [10:0]                 row_off;
  logic [lcse_pkg::RSUM_W:0]   sum_try;
  logic                        in_band, in_cols, hit, accept, close_row;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign close_row = row_end || frame_end;

  always_comb begin
    row_off = {1'b0, row} - {1'b0, cfg.band_top};
    in_band = (row >= cfg.band_top) && (row_off < cfg.band_rows) &&
              (int'(row) < lcse_pkg::MAX_ROWS);
    in_cols = ({1'b0, column} < cfg.image_width) &&
              (int'(column) < lcse_pkg::MAX_COLS);
    sum_try = {1'b0, sum_r} + (lcse_pkg::RSUM_W+1)'(column);
    // a pixel that would overflow the row counters is dropped
    hit     = (pixel != '0) && in_band && in_cols &&
              (cnt_r != '1) && !sum_try[lcse_pkg::RSUM_W];
    sum_upd = hit ? sum_try[lcse_pkg::RSUM_W-1:0] : sum_r;
    cnt_upd = hit ? cnt_r + 1'b1 : cnt_r;

    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      sum_nxt = close_row ? '0 : sum_upd;
      cnt_nxt = close_row ? '0 : cnt_upd;
    end

    push               = accept && close_row;
    push_rec.frame_end = frame_end;
    push_rec.cnt       = cnt_upd;
    push_rec.sum       = sum_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/lcse_div.sv @@
// ----------------------------------------------------------------------------
// lcse_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcse_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [lcse_pkg::DIV_NUM_W-1:0] num,
  input  logic [lcse_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [lcse_pkg::DIV_NUM_W-1:0] quo
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [lcse_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [lcse_pkg::DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [lcse_pkg::DIV_DEN_W-1:0] den_r, den_nxt;
  logic [lcse_pkg::DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [lcse_pkg::DIV_DEN_W:0]   trial, diff;
  logic                           ge;

  assign done = done_r;
  assign quo  = quo_r;

  always_comb begin
    trial    = {rem_r, quo_r[lcse_pkg::DIV_NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = lcse_pkg::DIV_CNT_W'(lcse_pkg::DIV_NUM_W - 1);
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      // remainder stays below the divisor, so one bit fewer suffices
      rem_nxt = ge ? diff[lcse_pkg::DIV_DEN_W-1:0] : trial[lcse_pkg::DIV_DEN_W-1:0];
      quo_nxt = {quo_r[lcse_pkg::DIV_NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

endmodule

@@ src/lcse_back.sv @@
// ----------------------------------------------------------------------------
// lcse_back
// Turns row records into centroids, averages them at frame end, computes the
// steering error and drive and holds the result in an output register.
// ----------------------------------------------------------------------------
module lcse_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lcse_pkg::cfg_t      cfg,
  input  lcse_pkg::row_rec_t  head_rec,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_err,
  output logic [16:0]         out_drv,
  output logic                out_found
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDIV = 3'd1;
  localparam logic [2:0] S_CHKF = 3'd2;
  localparam logic [2:0] S_FDIV = 3'd3;
  localparam logic [2:0] S_ERR  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_DRV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]                    state_r, state_nxt;
  logic [lcse_pkg::CSUM_W-1:0]   csum_r, csum_nxt;
  logic [lcse_pkg::RCNT_W-1:0]   rows_r, rows_nxt;
  logic                          fe_r, fe_nxt;
  logic signed [27:0]            diff_r, diff_nxt;
  logic signed [15:0]            err_r, err_nxt;
  logic signed [31:0]            prod_r, prod_nxt;
  logic signed [16:0]            drv_r, drv_nxt;
  logic                          found_r, found_nxt;
  logic                          ov_r, ov_nxt;
  logic [15:0]                   oerr_r, oerr_nxt;
  logic [16:0]                   odrv_r, odrv_nxt;
  logic                          ofound_r, ofound_nxt;

  logic                           div_start, div_done;
  logic [lcse_pkg::DIV_NUM_W-1:0] div_num, div_quo;
  logic [lcse_pkg::DIV_DEN_W-1:0] div_den;

  logic [lcse_pkg::CSUM_W+2:0]   csum_try;
  logic signed [27:0]            adj;
  logic signed [27:0]            off_q4, ctr_q4;
  logic signed [32:0]            negp;
  logic signed [18:0]            shr;
  logic                          load_out;

  lcse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid = ov_r;
  assign out_err   = oerr_r;
  assign out_drv   = odrv_r;
  assign out_found = ofound_r;
  assign load_out  = (state_r == S_OUT) && (!ov_r || out_ready);

  always_comb begin
    state_nxt  = state_r;
    csum_nxt   = csum_r;
    rows_nxt   = rows_r;
    fe_nxt     = fe_r;
    diff_nxt   = diff_r;
    err_nxt    = err_r;
    prod_nxt   = prod_r;
    drv_nxt    = drv_r;
    found_nxt  = found_r;
    pop        = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    ctr_q4     = 28'(signed'({1'b0, cfg.image_width[10:1], 4'b0000}));
    off_q4     = 28'(signed'({1'b0, cfg.center_offset, 4'b0000}));
    csum_try   = (lcse_pkg::CSUM_W+3)'(csum_r) + (lcse_pkg::CSUM_W+3)'(div_quo);
    adj        = diff_r[27] ? diff_r + off_q4 : diff_r - off_q4;
    negp       = 33'sd8192 - 33'(prod_r);
    shr        = 19'(negp >>> 14);

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop    = 1'b1;
          fe_nxt = head_rec.frame_end;
          if (head_rec.cnt != '0) begin
            // centroid in q.4: (sum*32 + n) / (2n)
            div_start = 1'b1;
            div_num   = {1'b0, head_rec.sum, 5'b00000} +
                        lcse_pkg::DIV_NUM_W'(head_rec.cnt);
            div_den   = {head_rec.cnt, 1'b0};
            state_nxt = S_RDIV;
          end else begin
            state_nxt = S_CHKF;
          end
        end
      end
      S_RDIV: begin
        if (div_done) begin
          if ((rows_r != '1) && (csum_try <= (lcse_pkg::CSUM_W+3)'(24'hFFFFFF))) begin
            csum_nxt = csum_try[lcse_pkg::CSUM_W-1:0];
            rows_nxt = rows_r + 1'b1;
          end
          state_nxt = S_CHKF;
        end
      end
      S_CHKF: begin
        if (!fe_r) begin
          state_nxt = S_IDLE;
        end else if (rows_r == '0) begin
          err_nxt   = '0;
          drv_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = {1'b0, csum_r, 1'b0} + lcse_pkg::DIV_NUM_W'(rows_r);
          div_den   = {rows_r, 1'b0};
          state_nxt = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_done) begin
          diff_nxt  = signed'({2'b00, div_quo}) - ctr_q4;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        if (adj > 28'sd32767) begin
          err_nxt = 16'sh7FFF;
        end else if (adj < -28'sd32768) begin
          err_nxt = 16'sh8000;
        end else begin
          err_nxt = adj[15:0];
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = cfg.steer_gain * err_r;
        state_nxt = S_DRV;
      end
      S_DRV: begin
        // round half up, then saturate to 17 bits
        if (shr > 19'sd65535) begin
          drv_nxt = 17'sh0FFFF;
        end else if (shr < -19'sd65536) begin
          drv_nxt = 17'sh10000;
        end else begin
          drv_nxt = shr[16:0];
        end
        found_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          csum_nxt  = '0;
          rows_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt     = ov_r;
    oerr_nxt   = oerr_r;
    odrv_nxt   = odrv_r;
    ofound_nxt = ofound_r;
    if (load_out) begin
      ov_nxt     = 1'b1;
      oerr_nxt   = err_r;
      odrv_nxt   = drv_r;
      ofound_nxt = found_r;
    end else if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      csum_r  <= '0;
      rows_r  <= '0;
      fe_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      csum_r  <= csum_nxt;
      rows_r  <= rows_nxt;
      fe_r    <= fe_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r   <= diff_nxt;
    err_r    <= err_nxt;
    prod_r   <= prod_nxt;
    drv_r    <= drv_nxt;
    found_r  <= found_nxt;
    oerr_r   <= oerr_nxt;
    odrv_r   <= odrv_nxt;
    ofound_r <= ofound_nxt;
  end

endmodule

@@ src/lcse_checker.sv @@
// ----------------------------------------------------------------------------
// lcse_checker
// Port-level checks of the line centroid steering error block.
// ----------------------------------------------------------------------------
module lcse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_pready
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an empty band reports zero error and drive
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 40'd0)
    else $error("nonzero fields without a line");

  // the padding above drive stays clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] == 7'd0)
    else $error("result padding not zero");

  // the register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("register port not ready");

endmodule

bind line_centroid_steering_error lcse_checker u_lcse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for line_centroid_steering_error: mask pixels are
// streamed in with random gaps, each accepted pixel updates a band-centroid
// predictor, and every frame-end result is compared field by field with the
// oldest predicted error, drive and line-found flag. Register settings change
// between idle phases: reset values, extremes, then random frames.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [7:0] pixel;
    logic [9:0] column;
    logic [9:0] row;
    logic       row_end;
    logic       frame_end;
  } mask_px_t;

  typedef struct packed {
    logic signed [15:0] steer_error;
    logic signed [16:0] drive;
    logic               line_found;
  } steer_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // pixel[7:0], column[17:8], row[27:18], zero pad
  logic        in_tlast = 1'b0; // frame_end
  logic        in_tuser = 1'b0; // row_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // steer_error[15:0], drive[32:16], zero pad
  logic        out_tuser;       // line_found
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  line_centroid_steering_error dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register shadow
  lcse_pkg::cfg_t shadow_cfg;
  logic [19:0]    col_sum;
  logic [10:0]    pix_cnt;
  logic [23:0]    cent_sum;
  logic [10:0]    line_rows;

  mask_px_t   px_pending_q[$];
  steer_res_t steer_expect_q[$];
  int         mismatches = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic close_row_model();
    longint s, n, c, cs;
    s = col_sum;
    n = pix_cnt;
    cs = cent_sum;
    if (n != 0) begin
      c = (s * 32 + n) / (2 * n);
      if (line_rows < 11'd2047 && cs + c <= 16777215) begin
        cent_sum  = cs + c;
        line_rows = line_rows + 11'd1;
      end
    end
    col_sum = '0;
    pix_cnt = '0;
  endtask

  task automatic track_pixel(input mask_px_t px);
    longint top, rows, w, r, col, s, n, mean, err, gain, drv;
    bit in_band, in_cols;
    steer_res_t res;
    top  = shadow_cfg.band_top;
    rows = shadow_cfg.band_rows;
    w    = shadow_cfg.image_width;
    r    = px.row;
    col  = px.column;
    s    = col_sum;
    in_band = (r >= top) && (r - top < rows) && (r < lcse_pkg::MAX_ROWS);
    in_cols = (col < w) && (col < lcse_pkg::MAX_COLS);
    if (px.pixel != 0 && in_band && in_cols && pix_cnt < 11'd2047 && s + col <= 1048575) begin
      col_sum = s + col;
      pix_cnt = pix_cnt + 11'd1;
    end
    if (px.row_end || px.frame_end)
      close_row_model();
    if (px.frame_end) begin
      if (line_rows == 0) begin
        res = '0;
      end else begin
        s = cent_sum;
        n = line_rows;
        mean = (s * 2 + n) / (2 * n);
        err = mean - (w / 2) * 16;
        // the center offset is added to a negative error and subtracted from any other
        if (err < 0)
          err = err + longint'(shadow_cfg.center_offset) * 16;
        else
          err = err - longint'(shadow_cfg.center_offset) * 16;
        if (err < -32768) err = -32768;
        if (err > 32767) err = 32767;
        gain = longint'($signed(shadow_cfg.steer_gain));
        drv = (-(gain * err) + 8192) >>> 14;
        if (drv < -65536) drv = -65536;
        if (drv > 65535) drv = 65535;
        res.steer_error = err[15:0];
        res.drive       = drv[16:0];
        res.line_found  = 1'b1;
      end
      steer_expect_q = {steer_expect_q, res};
      col_sum   = '0;
      pix_cnt   = '0;
      cent_sum  = '0;
      line_rows = '0;
    end
  endtask

  // pixel driver
  mask_px_t px_cur;
  int       px_gap = 0;
  bit       px_quiet = 1'b0;

  always @(posedge clk) begin : px_driver
    logic nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        track_pixel(px_cur);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (px_gap > 0) begin
          px_gap--;
        end else if (px_pending_q.size() != 0) begin
          px_cur = px_pending_q.pop_front();
          in_tdata <= {4'b0, px_cur.row, px_cur.column, px_cur.pixel};
          in_tuser <= px_cur.row_end;
          in_tlast <= px_cur.frame_end;
          nxt_valid = 1'b1;
          if ($urandom_range(0, 29) == 0) px_quiet = !px_quiet;
          px_gap = px_quiet ? 0 : $urandom_range(0, 18);
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // result monitor
  int res_wait = 0;
  int long_hold = 0;
  int res_seen = 0;
  bit res_quiet = 1'b0;

  always @(posedge clk) begin : res_monitor
    steer_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (steer_expect_q.size() == 0) begin
          report_mismatch("unexpected result", $signed(out_tdata[15:0]), -1);
        end else begin
          want = steer_expect_q.pop_front();
          if (out_tdata[15:0] !== want.steer_error)
            report_mismatch("steer_error", $signed(out_tdata[15:0]), want.steer_error);
          if (out_tdata[32:16] !== want.drive)
            report_mismatch("drive", $signed(out_tdata[32:16]), want.drive);
          if (out_tuser !== want.line_found)
            report_mismatch("line_found", out_tuser, want.line_found);
        end
        res_seen++;
        // one long hold while pixels keep coming, so the row queue backs up
        if (res_seen == 40) long_hold = 700;
        if ($urandom_range(0, 29) == 0) res_quiet = !res_quiet;
        res_wait = res_quiet ? 0 : $urandom_range(0, 18);
      end
      if (long_hold == 0 && $urandom_range(0, 4999) == 0)
        long_hold = $urandom_range(200, 600);
      if (long_hold > 0) begin
        long_hold--;
        out_tready <= 1'b0;
      end else if (res_wait > 0) begin
        res_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // stimulus helpers
  task automatic push_px(input int pixel, input int col, input int row,
                         input bit re, input bit fe);
    mask_px_t px;
    px.pixel     = pixel[7:0];
    px.column    = col[9:0];
    px.row       = row[9:0];
    px.row_end   = re;
    px.frame_end = fe;
    px_pending_q = {px_pending_q, px};
  endtask

  task automatic wait_idle(input int settle);
    while (px_pending_q.size() != 0 || in_tvalid || steer_expect_q.size() != 0)
      @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  function automatic logic [31:0] reg_mask(input logic [2:0] idx);
    case (idx)
      lcse_pkg::REG_BAND_TOP:      return 32'h3FF;
      lcse_pkg::REG_BAND_ROWS:     return 32'h7FF;
      lcse_pkg::REG_IMAGE_WIDTH:   return 32'h7FF;
      lcse_pkg::REG_CENTER_OFFSET: return 32'h3FF;
      default:                     return 32'hFFFF;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      lcse_pkg::REG_BAND_TOP:      shadow_cfg.band_top      = val[9:0];
      lcse_pkg::REG_BAND_ROWS:     shadow_cfg.band_rows     = val[10:0];
      lcse_pkg::REG_IMAGE_WIDTH:   shadow_cfg.image_width   = val[10:0];
      lcse_pkg::REG_CENTER_OFFSET: shadow_cfg.center_offset = val[9:0];
      lcse_pkg::REG_STEER_GAIN:    shadow_cfg.steer_gain    = val[15:0];
      default: ;
    endcase
    // read it back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if ((cfg_prdata & reg_mask(idx)) !== (val & reg_mask(idx)))
      report_mismatch("register readback", cfg_prdata & reg_mask(idx), val & reg_mask(idx));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic setup_regs(input int top, input int rows, input int w,
                            input int off, input int gain);
    write_reg(lcse_pkg::REG_BAND_TOP, top);
    write_reg(lcse_pkg::REG_BAND_ROWS, rows);
    write_reg(lcse_pkg::REG_IMAGE_WIDTH, w);
    write_reg(lcse_pkg::REG_CENTER_OFFSET, off);
    write_reg(lcse_pkg::REG_STEER_GAIN, gain);
  endtask

  // one frame: mostly raster rows around the band, sometimes noise or
  // missing row ends
  task automatic gen_frame(output int n_items);
    int nr, nc, r0, c0, w, span, k;
    bit re;
    n_items = 0;
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(1, 8);
      for (int i = 0; i < k; i++)
        push_px($urandom_range(0, 255), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1), (i == k - 1) || ($urandom_range(0, 7) == 0));
      n_items = k;
    end else begin
      w = shadow_cfg.image_width;
      span = (shadow_cfg.band_rows > 8) ? 8 : shadow_cfg.band_rows;
      r0 = shadow_cfg.band_top + 1024 - 2 + $urandom_range(0, span + 3);
      nr = $urandom_range(1, 5);
      nc = $urandom_range(1, (w > 10) ? 12 : w + 2);
      c0 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023 - nc) : 0;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          re = (c == nc - 1) && ($urandom_range(0, 11) != 0);
          if (r == nr - 1 && c == nc - 1 && $urandom_range(0, 3) == 0) re = 1'b0;
          push_px($urandom_range(0, 1) ? $urandom_range(1, 255) : 0, c0 + c,
                  (r0 + r) % 1024, re, (r == nr - 1) && (c == nc - 1));
          n_items++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int rand_items, since_drain, k;
    shadow_cfg.band_top      = lcse_pkg::RST_BAND_TOP;
    shadow_cfg.band_rows     = lcse_pkg::RST_BAND_ROWS;
    shadow_cfg.image_width   = lcse_pkg::RST_IMAGE_WIDTH;
    shadow_cfg.center_offset = lcse_pkg::RST_CENTER_OFFSET;
    shadow_cfg.steer_gain    = lcse_pkg::RST_STEER_GAIN;
    col_sum   = '0;
    pix_cnt   = '0;
    cent_sum  = '0;
    line_rows = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: band edges, width edge, zero pixel, frame end closing a row
    push_px(255, 0, 320, 0, 0);
    push_px(1, 639, 320, 0, 0);
    push_px(7, 640, 320, 0, 0);
    push_px(0, 100, 320, 1, 0);
    push_px(128, 300, 343, 1, 0);
    push_px(200, 10, 344, 1, 1);
    push_px(255, 5, 319, 0, 1);          // empty band
    push_px(3, 2, 330, 0, 0);
    push_px(9, 3, 330, 0, 1);            // frame end without row end
    push_px(255, 1023, 1023, 1, 1);
    wait_idle(300);

    setup_regs(0, 1024, 1024, 1023, 32'h8000);
    push_px(255, 1023, 0, 1, 0);
    push_px(1, 0, 1023, 1, 1);
    push_px(17, 512, 511, 1, 1);
    wait_idle(300);

    setup_regs(1023, 1, 1, 0, 32'h7FFF);
    push_px(9, 0, 1023, 1, 0);
    push_px(9, 1, 1023, 1, 1);
    push_px(9, 0, 1022, 0, 1);
    wait_idle(300);

    // zero rows and zero width accept nothing, then the widest band and width
    setup_regs(0, 0, 1024, 0, 0);
    push_px(255, 4, 0, 1, 1);
    wait_idle(300);
    setup_regs(0, 2047, 0, 5, 32'h4000);
    push_px(255, 0, 0, 1, 1);
    wait_idle(300);
    setup_regs(0, 2047, 2047, 1023, 0);
    push_px(85, 1000, 700, 1, 1);
    wait_idle(300);

    rand_items = 0;
    since_drain = 0;
    for (int ph = 0; ph < 8; ph++) begin
      setup_regs($urandom_range(0, 1023),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 12),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 24),
                 ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 8),
                 $urandom_range(0, 65535));
      while (rand_items < (ph + 1) * 182) begin
        gen_frame(k);
        rand_items += k;
        since_drain += k;
        // sender waits for every outstanding result now and then
        if (since_drain > 150) begin
          wait_idle(0);
          since_drain = 0;
        end
      end
      wait_idle(300);
    end

    if (mismatches == 0)
      $display("line_centroid_steering_error test passed");
    else
      $display("line_centroid_steering_error test failed");
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("line_centroid_steering_error test failed");
    $finish;
  end

endmodule
